/* sv/sohq_pkg.sv */
// Shared types, codes and sizes for the sequence-ordered hold-back queue.
package sohq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CLEAN  = 2'd2;
    localparam logic [1:0] REQ_TAKE   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Commands broadcast to every cell of the chain.
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_CMP  = 2'd1;
    localparam logic [1:0] CELL_INS  = 2'd2;
    localparam logic [1:0] CELL_SHL  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] seq_key;
        logic [15:0] payload_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_seq;
        logic [15:0] out_handle;
        logic [4:0]  removed_count;
        logic [4:0]  occupancy;
        logic        head_valid;
        logic [31:0] head_seq;
    } t_rsp;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [15:0] handle;
    } t_cell_cmd;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] handle;
        logic        lt;
        logic        eq;
    } t_cell_out;

endpackage

/* sv/sohq_cell.sv */
// One slot of the sorted chain: holds an entry and its compare flags.
module sohq_cell (
    input  logic                i_clk,
    input  sohq_pkg::t_cell_cmd i_cmd,
    input  logic                i_occ,
    input  sohq_pkg::t_cell_out i_left,
    input  sohq_pkg::t_cell_out i_right,
    output sohq_pkg::t_cell_out o_cell
);
    import sohq_pkg::*;

    logic [31:0] r_seq;
    logic [15:0] r_handle;
    logic        r_lt;
    logic        r_eq;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_CMP: begin
                r_lt <= i_occ && (r_seq < i_cmd.key);
                r_eq <= i_occ && (r_seq == i_cmd.key);
            end
            CELL_INS: begin
                // Entries below the key stay; the first slot not below it takes
                // the key, and every slot after that takes its left neighbor.
                if (!r_lt) begin
                    if (i_left.lt) begin
                        r_seq    <= i_cmd.key;
                        r_handle <= i_cmd.handle;
                    end else begin
                        r_seq    <= i_left.seq;
                        r_handle <= i_left.handle;
                    end
                end
            end
            CELL_SHL: begin
                r_seq    <= i_right.seq;
                r_handle <= i_right.handle;
            end
            default: begin
            end
        endcase
    end

    assign o_cell = '{seq: r_seq, handle: r_handle, lt: r_lt, eq: r_eq};

endmodule

/* sv/sequence_ordered_holdback_queue.sv */
// Top level of the sequence-ordered hold-back queue: control and result register.
// Usage:
// Requests enter on the in channel (i_in_valid, o_in_stall, i_in_data) and one
// result per request leaves on the out channel (o_out_valid, i_out_stall,
// o_out_data). A transaction completes on a rising edge with valid high and
// stall low. Entries live in a chain of DEPTH cells kept in ascending order;
// slot 0 is the head.
// Insert, remove and take-sequence pass through the compare/accept step and
// then the update step. The result register loads on the update edge, and a
// new request is taken only after the previous one has left the update step.
// Clean pops one entry per cycle through the chain until the head exceeds
// its bound or the chain is empty; its result register loads after the last pop.
// The request port stalls while a request is being worked on. A finished
// result waits in the output register; while the receiver stalls, the next
// request is still taken and compared, but its final step waits until the
// output register is free.
// Reset (synchronous, active low) empties the queue and sets the sequence
// counter to 1; no clearing pass is needed.
module sequence_ordered_holdback_queue #(
    parameter int DEPTH = sohq_pkg::DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sohq_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sohq_pkg::t_rsp o_out_data
);
    import sohq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_removed, n_removed;
    logic [31:0]   r_next_seq, n_next_seq;
    logic [1:0]    r_type, n_type;
    logic [31:0]   r_key, n_key;
    logic [15:0]   r_handle, n_handle;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    t_cell_cmd     w_cmd;
    t_cell_out     w_cell [DEPTH];
    logic [DEPTH-1:0] w_eq;
    logic          w_out_free;
    logic          w_dup;
    logic          w_full;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_out w_left;
            t_cell_out w_right;
            logic      w_occ;

            if (gi == 0) begin : g_first
                assign w_left = '{seq: '0, handle: '0, lt: 1'b1, eq: 1'b0};
            end else begin : g_inner
                assign w_left = w_cell[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_cell[gi];
            end else begin : g_mid
                assign w_right = w_cell[gi+1];
            end

            assign w_occ   = CW'(gi) < r_count;
            assign w_eq[gi] = w_cell[gi].eq;

            sohq_cell u_cell (
                .i_clk  (i_clk),
                .i_cmd  (w_cmd),
                .i_occ  (w_occ),
                .i_left (w_left),
                .i_right(w_right),
                .o_cell (w_cell[gi])
            );
        end
    endgenerate

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_dup      = |w_eq;
    assign w_full     = r_count == CW'(DEPTH);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_removed   = r_removed;
        n_next_seq  = r_next_seq;
        n_type      = r_type;
        n_key       = r_key;
        n_handle    = r_handle;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_cmd       = '{op: CELL_HOLD, key: r_key, handle: r_handle};

        case (r_state)
            S_IDLE: begin
                // The chain compares against the incoming key on the accept edge.
                w_cmd.key = i_in_data.seq_key;
                if (i_in_valid) begin
                    w_cmd.op  = CELL_CMP;
                    n_type    = i_in_data.req_type;
                    n_key     = i_in_data.seq_key;
                    n_handle  = i_in_data.payload_handle;
                    n_removed = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                // Default result: nothing changed, head taken from the chain as is.
                if (w_out_free) begin
                    n_out.status        = ST_OK;
                    n_out.out_seq       = '0;
                    n_out.out_handle    = '0;
                    n_out.removed_count = 5'(r_removed);
                    n_out.occupancy     = 5'(r_count);
                    n_out.head_valid    = r_count != '0;
                    n_out.head_seq      = (r_count != '0) ? w_cell[0].seq : '1;
                end
                case (r_type)
                    REQ_INSERT: begin
                        if (w_out_free) begin
                            if (w_dup) begin
                                n_out.status = ST_DUP;
                            end else if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_cmd.op         = CELL_INS;
                                n_count          = r_count + CW'(1);
                                n_out.occupancy  = 5'(n_count);
                                n_out.head_valid = 1'b1;
                                n_out.head_seq   = w_cell[0].lt ? w_cell[0].seq : r_key;
                            end
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    REQ_REMOVE: begin
                        if (w_out_free) begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                w_cmd.op            = CELL_SHL;
                                n_count             = r_count - CW'(1);
                                n_out.out_seq       = w_cell[0].seq;
                                n_out.out_handle    = w_cell[0].handle;
                                n_out.removed_count = 5'd1;
                                n_out.occupancy     = 5'(n_count);
                                n_out.head_valid    = n_count != '0;
                                n_out.head_seq      = (n_count != '0) ? w_cell[1].seq : '1;
                            end
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    REQ_CLEAN: begin
                        // Pop one head per cycle until the head exceeds the bound.
                        if (r_count != '0 && w_cell[0].seq <= r_key) begin
                            w_cmd.op  = CELL_SHL;
                            n_count   = r_count - CW'(1);
                            n_removed = r_removed + CW'(1);
                        end else if (w_out_free) begin
                            if (r_count == '0 && r_removed == '0) begin
                                n_out.status = ST_EMPTY;
                            end
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    REQ_TAKE: begin
                        if (w_out_free) begin
                            n_out.out_seq = r_next_seq;
                            n_next_seq    = r_next_seq + 32'd1;
                            n_out_valid   = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_removed   <= '0;
            r_next_seq  <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_removed   <= n_removed;
            r_next_seq  <= n_next_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_key    <= n_key;
        r_handle <= n_handle;
        r_out    <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_cell[0].seq < w_cell[1].seq))
        else $error("first two entries out of order");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request port free right after a transaction");

    a_empty_none_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_EMPTY) |->
        (o_out_data.removed_count == 5'd0 && !o_out_data.head_valid))
        else $error("empty status with popped entries or a head");
`endif

endmodule
